// ===== rtl/sncnt_pkg.sv =====
// Types and codes shared by the non-overlapping substring counter.
package sncnt_pkg;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 5;
    localparam int LEN_W   = 6;
    localparam int COUNT_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEXT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] pattern_index;
    } in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               empty_pattern;
    } out_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic rotate;
    } cell_ctl_t;

endpackage

// ===== rtl/substring_count_non_overlapping_core.sv =====
// Top level of the non-overlapping substring counter.
// Takes one word per cycle while in_ready is high: pattern loads, text bytes and end
// commands all go at full rate, and each text byte is compared against the whole window in
// the cycle it arrives. A chain of MAX_PATTERN cells holds the text window and the pattern,
// the pattern kept aligned to pattern_length as a ring. After a pattern_length write the
// ring turns one place per cycle until it lines up, and in_ready stays low meanwhile.
// Results go through a two-entry output queue; input keeps flowing while one count waits.
module substring_count_non_overlapping_core #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sncnt_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sncnt_pkg::in_t              in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sncnt_pkg::out_t             out_data
);
    import sncnt_pkg::*;

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]   cfg_len_reg;
    logic [IW-1:0]      rot_reg;
    logic [IW-1:0]      rot_next;
    logic [IW-1:0]      rot_target;
    logic [LW-1:0]      bytes_seen_reg;
    logic [LW-1:0]      bytes_seen_next;
    logic [LW-1:0]      blocked_reg;
    logic [LW-1:0]      blocked_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_t               out_data_reg;
    out_t               out_data_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    out_t               skid_data_reg;
    out_t               skid_data_next;

    logic [LW-1:0]      leff;
    logic               rotating;
    logic               accept;
    logic               load_en;
    logic               text_en;
    logic               end_en;
    logic               hit;
    logic               all_eq;
    int                 diff;
    logic [IW-1:0]      load_addr;
    cell_ctl_t          ctl;
    out_t               res;

    logic [BYTE_W-1:0]      text_q [MAX_PATTERN];
    logic [BYTE_W-1:0]      pat_q  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq;
    logic [MAX_PATTERN-1:0] care;
    logic [MAX_PATTERN-1:0] load;

    assign leff = (int'(cfg_len_reg) > MAX_PATTERN) ? LW'(MAX_PATTERN) : LW'(cfg_len_reg);
    assign rot_target = (leff == '0) ? IW'(MAX_PATTERN - 1) : IW'(leff - 1'b1);
    assign rotating   = (rot_reg != rot_target);
    assign rot_next   = (rot_reg == IW'(MAX_PATTERN - 1)) ? '0 : rot_reg + 1'b1;

    assign in_ready = !rotating && !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        load_en = 1'b0;
        text_en = 1'b0;
        end_en  = 1'b0;
        unique case (in_data.command)
            CMD_LOAD: load_en = accept && (int'(in_data.pattern_index) < MAX_PATTERN);
            CMD_TEXT: text_en = accept;
            CMD_END:  end_en  = accept;
            default:  ;
        endcase
    end

    always_comb
    begin
        diff = int'(rot_reg) - int'(in_data.pattern_index);
        if (diff < 0)
        begin
            diff = diff + MAX_PATTERN;
        end
        load_addr = IW'(diff);
    end

    assign ctl.shift  = text_en;
    assign ctl.clear  = end_en;
    assign ctl.rotate = rotating;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic [BYTE_W-1:0] text_in;
        logic [BYTE_W-1:0] pat_in;

        if (k == 0)
        begin : g_head
            assign text_in = in_data.data_byte;
            assign pat_in  = pat_q[MAX_PATTERN-1];
        end
        else
        begin : g_body
            assign text_in = text_q[k-1];
            assign pat_in  = pat_q[k-1];
        end

        assign load[k] = load_en && (load_addr == IW'(k));
        assign care[k] = (k < int'(leff));

        sncnt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .load      (load[k]),
            .load_byte (in_data.data_byte),
            .text_in   (text_in),
            .pat_in    (pat_in),
            .text_q    (text_q[k]),
            .pat_q     (pat_q[k]),
            .eq        (eq[k])
        );
    end

    assign all_eq = &(eq | ~care);

    assign bytes_seen_next = (bytes_seen_reg < LW'(MAX_PATTERN)) ?
                             bytes_seen_reg + 1'b1 : bytes_seen_reg;
    assign hit = (leff != '0) && (blocked_reg == '0) &&
                 (bytes_seen_next >= leff) && all_eq;

    always_comb
    begin
        blocked_next = blocked_reg;
        count_next   = count_reg;
        if (end_en)
        begin
            blocked_next = '0;
            count_next   = '0;
        end
        else if (text_en && (leff != '0))
        begin
            if (blocked_reg != '0)
            begin
                blocked_next = blocked_reg - 1'b1;
            end
            else if (hit)
            begin
                blocked_next = leff - 1'b1;
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    assign res.match_count   = (leff == '0) ? '0 : count_reg;
    assign res.empty_pattern = (leff == '0);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = end_en;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = end_en;
                out_data_next  = res;
            end
        end
        else if (end_en)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg    <= '0;
            rot_reg        <= IW'(MAX_PATTERN - 1);
            bytes_seen_reg <= '0;
            blocked_reg    <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_len_reg <= cfg_wdata;
            end
            if (rotating)
            begin
                rot_reg <= rot_next;
            end
            if (end_en)
            begin
                bytes_seen_reg <= '0;
            end
            else if (text_en)
            begin
                bytes_seen_reg <= bytes_seen_next;
            end
            blocked_reg    <= blocked_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_no_accept_while_rotating: assert property (@(posedge clk) disable iff (!rst_n)
        rotating |-> !in_ready)
        else $error("word accepted while pattern ring is turning");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '1) && !end_en |=> (count_reg == '1))
        else $error("match count wrapped");

    a_blocked_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(blocked_reg) < MAX_PATTERN)
        else $error("blocked byte count out of range");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        end_en |=> (count_reg == '0) && (bytes_seen_reg == '0) && (blocked_reg == '0))
        else $error("end command did not clear text state");
`endif

endmodule

// ===== rtl/sncnt_cell.sv =====
// Chain cell: a text window byte, a pattern byte, eq of text_in and pattern.
module sncnt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sncnt_pkg::cell_ctl_t       ctl,
    input  logic                       load,
    input  logic [sncnt_pkg::BYTE_W-1:0] load_byte,
    input  logic [sncnt_pkg::BYTE_W-1:0] text_in,
    input  logic [sncnt_pkg::BYTE_W-1:0] pat_in,
    output logic [sncnt_pkg::BYTE_W-1:0] text_q,
    output logic [sncnt_pkg::BYTE_W-1:0] pat_q,
    output logic                       eq
);
    import sncnt_pkg::*;

    logic [BYTE_W-1:0] text_reg;
    logic [BYTE_W-1:0] text_next;
    logic [BYTE_W-1:0] pat_reg;
    logic [BYTE_W-1:0] pat_next;

    always_comb
    begin
        text_next = text_reg;
        if (ctl.clear)
        begin
            text_next = '0;
        end
        else if (ctl.shift)
        begin
            text_next = text_in;
        end
    end

    always_comb
    begin
        pat_next = pat_reg;
        if (load)
        begin
            pat_next = load_byte;
        end
        else if (ctl.rotate)
        begin
            pat_next = pat_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_reg <= '0;
        end
        else
        begin
            text_reg <= text_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    assign text_q = text_reg;
    assign pat_q  = pat_reg;
    assign eq     = (text_in == pat_reg);

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the non-overlapping substring counter core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sncnt_pkg::*;

    localparam int MAX_PATTERN = 32;
    localparam int SETTLE_CYCLES = MAX_PATTERN + 8;
    localparam int WORD_TARGET = 1700;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef enum bit {ROW_WORD, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   arg;
        bit                 typed;
        logic [COUNT_W-1:0] exp_count;
        logic               exp_empty;
    } row_t;

    localparam row_t DIRECTED [24] = '{
        '{ROW_WORD, CMD_END,  8'h00, 6'd0,  1'b1, 32'd0, 1'b1},
        '{ROW_WORD, CMD_TEXT, 8'hFF, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_NOP,  8'hFF, 6'd31, 1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_END,  8'hFF, 6'd31, 1'b1, 32'd0, 1'b1},
        '{ROW_CFG,  CMD_LOAD, 8'h00, 6'd2,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_LOAD, 8'h00, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_LOAD, 8'h00, 6'd1,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_TEXT, 8'h00, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_END,  8'h00, 6'd0,  1'b1, 32'd0, 1'b0},
        '{ROW_WORD, CMD_TEXT, 8'h00, 6'd31, 1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_TEXT, 8'h00, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_TEXT, 8'h00, 6'd31, 1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_TEXT, 8'h00, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_END,  8'h00, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_TEXT, 8'h00, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_CFG,  CMD_LOAD, 8'h00, 6'd1,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_LOAD, 8'hFF, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_TEXT, 8'hFF, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_TEXT, 8'hFF, 6'd31, 1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_LOAD, 8'hFF, 6'd31, 1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_END,  8'h00, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_CFG,  CMD_LOAD, 8'h00, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_TEXT, 8'h00, 6'd0,  1'b0, 32'd0, 1'b0},
        '{ROW_WORD, CMD_END,  8'h00, 6'd0,  1'b1, 32'd0, 1'b1}
    };

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [LEN_W-1:0] cfg_wdata;
    logic            in_valid;
    logic            in_ready;
    in_t             in_data;
    logic            out_valid;
    logic            out_ready;
    out_t            out_data;

    logic [BYTE_W-1:0]  pat_shadow [MAX_PATTERN];
    logic [BYTE_W-1:0]  win_shadow [MAX_PATTERN];
    int unsigned        seen_bytes;
    int unsigned        blocked_left;
    logic [COUNT_W-1:0] hits;
    logic [LEN_W-1:0]   pat_len;

    out_t expected_counts [$];
    int   words_sent;
    int   results_seen;
    bit   mismatch_seen;
    bit   tx_calm;
    bit   rx_calm;

    substring_count_non_overlapping_core #(
        .MAX_PATTERN(MAX_PATTERN)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("substring_count_non_overlapping_core test failed");
        $finish;
    end

    function automatic void clear_text();
        int k;
        for (k = 0; k < MAX_PATTERN; k++)
        begin
            win_shadow[k] = '0;
        end
        seen_bytes = 0;
        blocked_left = 0;
        hits = '0;
    endfunction

    function automatic bit count_step(input in_t w, output out_t res);
        int unsigned len;
        int k;
        bit hit;
        len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
        res = '0;
        case (w.command)
            CMD_LOAD:
            begin
                pat_shadow[w.pattern_index] = w.data_byte;
            end
            CMD_TEXT:
            begin
                for (k = MAX_PATTERN - 1; k > 0; k--)
                begin
                    win_shadow[k] = win_shadow[k-1];
                end
                win_shadow[0] = w.data_byte;
                if (seen_bytes < MAX_PATTERN)
                begin
                    seen_bytes++;
                end
                if (len != 0)
                begin
                    if (blocked_left != 0)
                    begin
                        blocked_left--;
                    end
                    else if (seen_bytes >= len)
                    begin
                        hit = 1'b1;
                        for (k = 0; k < len; k++)
                        begin
                            if (win_shadow[k] != pat_shadow[len-1-k])
                            begin
                                hit = 1'b0;
                            end
                        end
                        if (hit)
                        begin
                            if (hits != '1)
                            begin
                                hits++;
                            end
                            blocked_left = len - 1;
                        end
                    end
                end
            end
            CMD_END:
            begin
                res.match_count = (len == 0) ? '0 : hits;
                res.empty_pattern = (len == 0);
                clear_text();
                return 1'b1;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    task automatic send_word(input in_t w, input bit typed, input out_t typed_res);
        int gap;
        out_t res;
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 39) == 0)
        begin
            tx_calm = !tx_calm;
        end
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (count_step(w, res))
        begin
            expected_counts.push_back(typed ? typed_res : res);
        end
        if (w.command != CMD_NOP)
        begin
            words_sent++;
        end
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                        input logic [INDEX_W-1:0] idx);
        in_t w;
        w.command = cmd;
        w.data_byte = b;
        w.pattern_index = idx;
        send_word(w, 1'b0, '0);
    endtask

    // drop valid, wait out every pending count and the block's own work
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        settle_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        pat_len = value;
    endtask

    function automatic logic [BYTE_W-1:0] pick(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
        return ($urandom_range(0, 1) != 0) ? a : b;
    endfunction

    task automatic run_phase();
        int unsigned r;
        int unsigned eff;
        int unsigned n_texts;
        int unsigned target;
        int unsigned n;
        int unsigned span;
        int unsigned j;
        int unsigned t;
        logic [LEN_W-1:0]  new_len;
        logic [BYTE_W-1:0] sym_a;
        logic [BYTE_W-1:0] sym_b;
        r = $urandom_range(0, 99);
        if (r < 5)
            new_len = 6'd0;
        else if (r < 10)
            new_len = LEN_W'(MAX_PATTERN);
        else if (r < 14)
            new_len = LEN_W'($urandom_range(MAX_PATTERN + 1, 63));
        else if (r < 25)
            new_len = LEN_W'($urandom_range(5, MAX_PATTERN - 1));
        else
            new_len = LEN_W'($urandom_range(1, 4));
        write_length(new_len);
        eff = (new_len > MAX_PATTERN) ? MAX_PATTERN : new_len;
        sym_a = BYTE_W'($urandom_range(0, 255));
        sym_b = ($urandom_range(0, 3) == 0) ? ~sym_a : BYTE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 7)
        begin
            for (j = 0; j < eff; j++)
            begin
                send(CMD_LOAD, pick(sym_a, sym_b), INDEX_W'(j));
            end
        end
        n_texts = $urandom_range(1, 4);
        for (t = 0; t < n_texts; t++)
        begin
            target = $urandom_range(0, 3 * eff + 6);
            n = 0;
            while (n < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 45 && eff != 0)
                begin
                    for (j = 0; j < eff; j++)
                    begin
                        send(CMD_TEXT, pat_shadow[j], INDEX_W'($urandom_range(0, 31)));
                    end
                    n += eff;
                end
                else if (r < 60 && eff > 1)
                begin
                    span = $urandom_range(1, eff - 1);
                    for (j = 0; j < span; j++)
                    begin
                        send(CMD_TEXT, pat_shadow[j], INDEX_W'($urandom_range(0, 31)));
                    end
                    n += span;
                end
                else if (r < 90)
                begin
                    send(CMD_TEXT, pick(sym_a, sym_b), INDEX_W'($urandom_range(0, 31)));
                    n++;
                end
                else if (r < 95)
                begin
                    send(CMD_TEXT, BYTE_W'($urandom_range(0, 255)),
                         INDEX_W'($urandom_range(0, 31)));
                    n++;
                end
                else if (r < 98)
                begin
                    send(CMD_LOAD, BYTE_W'($urandom_range(0, 255)),
                         INDEX_W'($urandom_range(0, 31)));
                end
                else
                begin
                    send(CMD_NOP, BYTE_W'($urandom_range(0, 255)),
                         INDEX_W'($urandom_range(0, 31)));
                end
            end
            // leave the last text open now and then so the next length applies mid-text
            if (t != n_texts - 1 || $urandom_range(0, 3) != 0)
            begin
                send(CMD_END, BYTE_W'($urandom_range(0, 255)),
                     INDEX_W'($urandom_range(0, 31)));
            end
        end
    endtask

    initial
    begin : result_sink
        int stall;
        out_t want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            // hold off right after the directed counts so the queued counts fill the block
            if (results_seen == 6 || results_seen == 140)
                stall = 400;
            else
                stall = rx_calm ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 39) == 0)
            begin
                rx_calm = !rx_calm;
            end
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            results_seen++;
            if (expected_counts.size() == 0)
            begin
                $display("%0t: unexpected word count=%0d empty=%0b", $time,
                         out_data.match_count, out_data.empty_pattern);
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = expected_counts.pop_front();
                if (out_data.match_count !== want.match_count)
                begin
                    $display("%0t: match_count expected %0d actual %0d", $time,
                             want.match_count, out_data.match_count);
                    mismatch_seen = 1'b1;
                end
                if (out_data.empty_pattern !== want.empty_pattern)
                begin
                    $display("%0t: empty_pattern expected %0b actual %0b", $time,
                             want.empty_pattern, out_data.empty_pattern);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        in_t w;
        out_t typed_res;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        words_sent = 0;
        results_seen = 0;
        mismatch_seen = 1'b0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        pat_len = '0;
        for (i = 0; i < MAX_PATTERN; i++)
        begin
            pat_shadow[i] = '0;
        end
        clear_text();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_CFG)
            begin
                write_length(DIRECTED[r].arg);
            end
            else
            begin
                w.command = DIRECTED[r].cmd;
                w.data_byte = DIRECTED[r].data;
                w.pattern_index = DIRECTED[r].arg[INDEX_W-1:0];
                typed_res.match_count = DIRECTED[r].exp_count;
                typed_res.empty_pattern = DIRECTED[r].exp_empty;
                send_word(w, DIRECTED[r].typed, typed_res);
            end
        end

        // queue counts back to back while the receiver holds off
        for (i = 0; i < 4; i++)
        begin
            send(CMD_END, 8'h00, 5'd0);
        end

        // fill the whole pattern store before any longer pattern is used
        for (i = 0; i < MAX_PATTERN; i++)
        begin
            send(CMD_LOAD, BYTE_W'($urandom_range(0, 255)), INDEX_W'(i));
        end

        while (words_sent < WORD_TARGET)
        begin
            run_phase();
        end

        settle_idle();
        if (!mismatch_seen && expected_counts.size() == 0)
        begin
            $display("substring_count_non_overlapping_core test passed");
        end
        else
        begin
            $display("substring_count_non_overlapping_core test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sncnt_pkg.sv
rtl/sncnt_cell.sv
rtl/substring_count_non_overlapping_core.sv
bench/testbench.sv
